// ===== sv/vsc_pkg.sv =====
// Shared types, codes, constants and fixed-point helpers for the silhouette carving block.
package vsc_pkg;

  localparam int VOXEL_W    = 24;
  localparam int PIX_W      = 10;
  localparam int COEF_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [1:0] {
    MODE_PIXEL = 2'd0,
    MODE_COEF  = 2'd1,
    MODE_VOXEL = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_DIM_X        = 3'd2,
    REG_DIM_Y        = 3'd3,
    REG_DIM_Z        = 3'd4
  } cfg_reg_e;

  localparam int NUM_COEF  = 20;
  localparam int COEF_FX   = 0;
  localparam int COEF_FY   = 1;
  localparam int COEF_CX   = 2;
  localparam int COEF_CY   = 3;
  localparam int COEF_R0   = 4;
  localparam int COEF_T0   = 13;
  localparam int COEF_ORG0 = 16;
  localparam int COEF_SIZE = 19;

  localparam logic signed [1:0] LABEL_CARVED = -2'sd1;
  localparam logic signed [1:0] LABEL_UNSEEN = 2'sd0;
  localparam logic signed [1:0] LABEL_KEPT   = 2'sd1;

  // Sideband that rides along the pipeline with every voxel and pixel item.
  typedef struct packed {
    logic                vox;
    logic [VOXEL_W-1:0]  tag;
    logic signed [1:0]   label;
    logic [PIX_W-1:0]    pix_x;
    logic [PIX_W-1:0]    pix_y;
    logic                mask_bit;
  } side_t;

  typedef struct packed {
    logic [VOXEL_W-1:0]  tag;
    logic signed [1:0]   label;
    logic                view;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // Q16.16 rescale, truncating toward zero.
  function automatic logic signed [47:0] trunc16(input logic signed [63:0] v);
    logic signed [63:0] b;
    b = v + (v[63] ? 64'sd65535 : 64'sd0);
    return b[63:16];
  endfunction

endpackage

// ===== sv/vsc_in_if.sv =====
// Input stream channel: voxel, pixel and coefficient items.
interface vsc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [9:0]         pixel_x;
  logic [9:0]         pixel_y;
  logic               mask_nonzero;
  logic [4:0]         coef_index;
  logic signed [31:0] coef_value;
  logic [23:0]        voxel_index;
  logic signed [1:0]  label_in;

  modport source (output valid, mode, pixel_x, pixel_y, mask_nonzero, coef_index,
                  coef_value, voxel_index, label_in, input ready);
  modport sink   (input valid, mode, pixel_x, pixel_y, mask_nonzero, coef_index,
                  coef_value, voxel_index, label_in, output ready);
endinterface

// ===== sv/vsc_out_if.sv =====
// Output stream channel: one updated label per voxel.
interface vsc_out_if;
  logic              valid;
  logic              ready;
  logic [23:0]       voxel_tag;
  logic signed [1:0] label_out;
  logic              in_view;

  modport source (output valid, voxel_tag, label_out, in_view, input ready);
  modport sink   (input valid, voxel_tag, label_out, in_view, output ready);
endinterface

// ===== sv/vsc_div.sv =====
// Pipelined unsigned restoring divider with a sideband that travels with each item.
module vsc_div #(
  parameter int DW  = 24,
  parameter int VW  = 9,
  parameter int BPS = 4,
  parameter int PW  = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [PW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o,
  output logic [PW-1:0] side_o,
  output logic          busy_o
);

  localparam int NS = (DW + BPS - 1) / BPS;

  logic [NS-1:0] v_q;
  logic [VW-1:0] rem_q [NS];
  logic [DW-1:0] dq_q  [NS];
  logic [VW-1:0] dvs_q [NS];
  logic [PW-1:0] side_q[NS];
  logic [VW-1:0] rem_d [NS];
  logic [DW-1:0] dq_d  [NS];

  always_comb begin
    logic [VW:0]   trial;
    logic [VW-1:0] r;
    logic [DW-1:0] d;
    logic [VW-1:0] dvs;
    for (int s = 0; s < NS; s++) begin
      r   = (s == 0) ? '0 : rem_q[s-1];
      d   = (s == 0) ? dividend_i : dq_q[s-1];
      dvs = (s == 0) ? divisor_i : dvs_q[s-1];
      for (int b = 0; b < BPS; b++) begin
        if (s * BPS + b < DW) begin
          trial = {r, d[DW-1]};
          d     = {d[DW-2:0], 1'b0};
          if (trial >= {1'b0, dvs}) begin
            trial = trial - {1'b0, dvs};
            d[0]  = 1'b1;
          end
          r = trial[VW-1:0];
        end
      end
      rem_d[s] = r;
      dq_d[s]  = d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NS; s++) begin
        rem_q[s]  <= rem_d[s];
        dq_q[s]   <= dq_d[s];
        dvs_q[s]  <= (s == 0) ? divisor_i : dvs_q[s-1];
        side_q[s] <= (s == 0) ? side_i : side_q[s-1];
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign quot_o  = dq_q[NS-1];
  assign rem_o   = rem_q[NS-1];
  assign side_o  = side_q[NS-1];
  assign busy_o  = |v_q;

endmodule

// ===== sv/vsc_mask.sv =====
// Silhouette mask memory, one bit per pixel, registered read.
module vsc_mask #(
  parameter int DEPTH = 1048576,
  parameter int AW    = 20
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic          wdata_i,
  output logic          rdata_o
);

  logic mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

// ===== sv/vsc_ofifo.sv =====
// Two-entry result buffer that decouples the pipeline from the output channel.
module vsc_ofifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vsc_pkg::res_t data_i,
  output logic          full_o,
  vsc_out_if.source     out_if
);
  import vsc_pkg::*;

  logic [1:0] count_q;
  logic       wp_q;
  logic       rp_q;
  res_t       buf_q [2];
  res_t       head;
  logic       pop;

  assign pop    = out_if.valid && out_if.ready;
  assign full_o = count_q[1];
  assign head   = buf_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= data_i;
  end

  assign out_if.valid     = (count_q != 2'd0);
  assign out_if.voxel_tag = head.tag;
  assign out_if.label_out = head.label;
  assign out_if.in_view   = head.view;

endmodule

// ===== sv/voxel_silhouette_carving.sv =====
// Top level: streaming space carving of voxels against one camera silhouette.
//
//  channel   | dir | handshake     | carries
//  ----------+-----+---------------+-------------------------------------------
//  in_if     | in  | valid/ready   | pixel load, coefficient load, voxel
//  out_if    | out | valid/ready   | voxel tag, updated label, in-view flag
//  cfg       | in  | cfg_we_i      | image size and volume dimensions
//
// One voxel transaction enters per cycle unless the pipeline is frozen or a coefficient load
// is waiting; its path runs through the two index dividers, the 48-bit depth dividers
// (4 quotient bits a stage) and the mask memory read. Pixel loads ride the same pipeline
// and write the mask at the read stage, so mask traffic stays in order with voxels.
// A coefficient load waits until the pipeline is empty.
// Reset clears control state only; the mask and coefficients hold garbage until loaded.
// A full output buffer freezes the whole pipeline in place once a finished voxel waits.
module voxel_silhouette_carving #(
  parameter int MAX_IMAGE_WIDTH  = 1024,
  parameter int MAX_IMAGE_HEIGHT = 1024,
  parameter int MAX_DIM          = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  vsc_in_if.sink                          in_if,
  vsc_out_if.source                       out_if,
  input  logic                            cfg_we_i,
  input  logic [vsc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vsc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import vsc_pkg::*;

  localparam int DIMW  = $clog2(MAX_DIM + 1);
  localparam int XW    = $clog2(MAX_IMAGE_WIDTH);
  localparam int YW    = $clog2(MAX_IMAGE_HEIGHT);
  localparam int DEPTH = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $bits(side_t);
  localparam int BPS   = 4;

  // ---------------- configuration registers ----------------
  logic [10:0] img_w_q, img_h_q;
  logic [8:0]  dim_x_q, dim_y_q, dim_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= 11'd1024;
      img_h_q <= 11'd1024;
      dim_x_q <= 9'd256;
      dim_y_q <= 9'd256;
      dim_z_q <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  img_w_q <= cfg_wdata_i[10:0];
        REG_IMAGE_HEIGHT: img_h_q <= cfg_wdata_i[10:0];
        REG_DIM_X:        dim_x_q <= cfg_wdata_i[8:0];
        REG_DIM_Y:        dim_y_q <= cfg_wdata_i[8:0];
        REG_DIM_Z:        dim_z_q <= cfg_wdata_i[8:0];
        default:          ;
      endcase
    end
  end

  // Zero dims act as one, oversize dims saturate at the maximum.
  function automatic logic [DIMW-1:0] clamp_dim(input logic [8:0] d);
    if (d == 9'd0) return DIMW'(1);
    else if (12'(d) > 12'(MAX_DIM)) return DIMW'(MAX_DIM);
    else return DIMW'(d);
  endfunction

  function automatic logic signed [31:0] ratio_sat(input logic [47:0] q, input logic neg);
    logic over;
    over = |q[47:31];
    if (neg) return over ? 32'sh80000000 : (~q[31:0] + 32'd1);
    else return over ? 32'sh7fffffff : q[31:0];
  endfunction

  logic [DIMW-1:0] dx, dy, dz;
  logic [12:0]     wd, ht;

  assign dx = clamp_dim(dim_x_q);
  assign dy = clamp_dim(dim_y_q);
  assign dz = clamp_dim(dim_z_q);
  assign wd = (13'(img_w_q) > 13'(MAX_IMAGE_WIDTH))  ? 13'(MAX_IMAGE_WIDTH)  : 13'(img_w_q);
  assign ht = (13'(img_h_q) > 13'(MAX_IMAGE_HEIGHT)) ? 13'(MAX_IMAGE_HEIGHT) : 13'(img_h_q);

  // ---------------- flow control ----------------
  logic en, busy, in_acc, fifo_full, push;
  logic a_busy, b_busy, xd_busy, yd_busy;

  logic m_valid_q;
  side_t m_side_q;

  // Freeze everything while a finished voxel has nowhere to go.
  assign en = !(m_valid_q && m_side_q.vox && fifo_full);
  assign in_if.ready = en && !(in_if.valid && (in_if.mode == MODE_COEF) && busy);
  assign in_acc = in_if.valid && in_if.ready;

  // ---------------- coefficient table ----------------
  logic signed [31:0] coef_q [NUM_COEF];

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_if.mode == MODE_COEF) && (in_if.coef_index < 5'(NUM_COEF))) begin
      coef_q[in_if.coef_index] <= in_if.coef_value;
    end
  end

  // ---------------- index unravel: k, then i and j ----------------
  side_t                in_side;
  logic                 a_valid;
  logic [VOXEL_W-1:0]   a_quot;
  logic [DIMW-1:0]      a_rem;
  logic [SW-1:0]        a_side;

  assign in_side.vox      = (in_if.mode == MODE_VOXEL);
  assign in_side.tag      = in_if.voxel_index;
  assign in_side.label    = in_if.label_in;
  assign in_side.pix_x    = in_if.pixel_x;
  assign in_side.pix_y    = in_if.pixel_y;
  assign in_side.mask_bit = in_if.mask_nonzero;

  vsc_div #(.DW(VOXEL_W), .VW(DIMW), .BPS(BPS), .PW(SW)) u_div_k (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_acc && ((in_if.mode == MODE_VOXEL) || (in_if.mode == MODE_PIXEL))),
    .dividend_i(in_if.voxel_index), .divisor_i(dz), .side_i(in_side),
    .valid_o(a_valid), .quot_o(a_quot), .rem_o(a_rem), .side_o(a_side), .busy_o(a_busy)
  );

  logic                 b_valid;
  logic [VOXEL_W-1:0]   b_quot;
  logic [DIMW-1:0]      b_rem;
  logic [SW+DIMW-1:0]   b_side;

  vsc_div #(.DW(VOXEL_W), .VW(DIMW), .BPS(BPS), .PW(SW + DIMW)) u_div_ij (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a_valid),
    .dividend_i(a_quot), .divisor_i(dy), .side_i({a_side, a_rem}),
    .valid_o(b_valid), .quot_o(b_quot), .rem_o(b_rem), .side_o(b_side), .busy_o(b_busy)
  );

  // ---------------- voxel centre: index * size, then + origin ----------------
  logic signed [24:0] idx_s [3];
  assign idx_s[0] = $signed({1'b0, b_quot});
  assign idx_s[1] = $signed({1'b0, 24'(b_rem)});
  assign idx_s[2] = $signed({1'b0, 24'(b_side[DIMW-1:0])});

  logic               p1_valid_q, p2_valid_q, r1_valid_q, r2_valid_q, r3_valid_q;
  side_t              p1_side_q, p2_side_q, r1_side_q, r2_side_q, r3_side_q;
  logic               p1_vol_q, p2_vol_q, r1_vol_q, r2_vol_q, r3_vol_q;
  logic signed [56:0] p1_prod_q [3];
  logic signed [31:0] p2_p_q    [3];
  logic signed [63:0] r1_prod_q [9];
  logic signed [47:0] r2_tr_q   [9];
  logic signed [31:0] r3_cam_q  [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_side_q <= side_t'(b_side[SW+DIMW-1:DIMW]);
      p1_vol_q  <= (b_quot < VOXEL_W'(dx));
      for (int a = 0; a < 3; a++) p1_prod_q[a] <= idx_s[a] * coef_q[COEF_SIZE];

      p2_side_q <= p1_side_q;
      p2_vol_q  <= p1_vol_q;
      for (int a = 0; a < 3; a++)
        p2_p_q[a] <= sat32(64'(p1_prod_q[a]) + 64'(coef_q[COEF_ORG0 + a]));

      // Rotation products, one per matrix entry.
      r1_side_q <= p2_side_q;
      r1_vol_q  <= p2_vol_q;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          r1_prod_q[3*r+c] <= coef_q[COEF_R0 + 3*r + c] * p2_p_q[c];

      r2_side_q <= r1_side_q;
      r2_vol_q  <= r1_vol_q;
      for (int n = 0; n < 9; n++) r2_tr_q[n] <= trunc16(r1_prod_q[n]);

      r3_side_q <= r2_side_q;
      r3_vol_q  <= r2_vol_q;
      for (int r = 0; r < 3; r++)
        r3_cam_q[r] <= sat32(64'(r2_tr_q[3*r]) + 64'(r2_tr_q[3*r+1]) +
                             64'(r2_tr_q[3*r+2]) + 64'(coef_q[COEF_T0 + r]));
    end
  end

  // ---------------- perspective divide ----------------
  logic        pz_pos;
  logic [31:0] mag_x, mag_y, depth;

  // Non-positive depth divides by one; the flag discards the result.
  assign pz_pos = !r3_cam_q[2][31] && (|r3_cam_q[2]);
  assign depth  = pz_pos ? r3_cam_q[2] : 32'd1;
  assign mag_x  = r3_cam_q[0][31] ? (~r3_cam_q[0] + 32'd1) : r3_cam_q[0];
  assign mag_y  = r3_cam_q[1][31] ? (~r3_cam_q[1] + 32'd1) : r3_cam_q[1];

  logic          xd_valid, yd_valid;
  logic [47:0]   xd_quot, yd_quot;
  logic [SW+2:0] xd_side;
  logic          yd_neg;

  vsc_div #(.DW(48), .VW(32), .BPS(BPS), .PW(SW + 3)) u_div_u (
    .clk_i, .rst_ni, .en_i(en), .valid_i(r3_valid_q),
    .dividend_i({mag_x, 16'h0000}), .divisor_i(depth),
    .side_i({r3_side_q, r3_vol_q, pz_pos, r3_cam_q[0][31]}),
    .valid_o(xd_valid), .quot_o(xd_quot), .rem_o(), .side_o(xd_side), .busy_o(xd_busy)
  );

  vsc_div #(.DW(48), .VW(32), .BPS(BPS), .PW(1)) u_div_v (
    .clk_i, .rst_ni, .en_i(en), .valid_i(r3_valid_q),
    .dividend_i({mag_y, 16'h0000}), .divisor_i(depth), .side_i(r3_cam_q[1][31]),
    .valid_o(yd_valid), .quot_o(yd_quot), .rem_o(), .side_o(yd_neg), .busy_o(yd_busy)
  );

  // ---------------- focal scale, offset, pixel and bounds ----------------
  logic               t0_valid_q, t1_valid_q, t2_valid_q, t3_valid_q;
  side_t              t0_side_q, t1_side_q, t2_side_q, t3_side_q;
  logic               t0_ok_q, t1_ok_q, t2_ok_q, t3_view_q;
  logic signed [31:0] t0_ru_q, t0_rv_q;
  logic signed [63:0] t1_pu_q, t1_pv_q;
  logic signed [48:0] t2_u_q, t2_v_q;
  logic [XW-1:0]      t3_u_q;
  logic [YW-1:0]      t3_w_q;
  logic [47:0]        u_raw, w_raw;
  logic               u_in, w_in;

  assign u_raw = trunc16(64'(t2_u_q));
  assign w_raw = trunc16(64'(t2_v_q));
  assign u_in  = !u_raw[47] && (u_raw < 48'(wd));
  assign w_in  = !w_raw[47] && (w_raw < 48'(ht));

  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_side_q <= side_t'(xd_side[SW+2:3]);
      t0_ok_q   <= xd_side[2] && xd_side[1];
      t0_ru_q   <= ratio_sat(xd_quot, xd_side[0]);
      t0_rv_q   <= ratio_sat(yd_quot, yd_neg);

      t1_side_q <= t0_side_q;
      t1_ok_q   <= t0_ok_q;
      t1_pu_q   <= t0_ru_q * coef_q[COEF_FX];
      t1_pv_q   <= t0_rv_q * coef_q[COEF_FY];

      t2_side_q <= t1_side_q;
      t2_ok_q   <= t1_ok_q;
      t2_u_q    <= 49'(trunc16(t1_pu_q)) + 49'(coef_q[COEF_CX]);
      t2_v_q    <= 49'(trunc16(t1_pv_q)) + 49'(coef_q[COEF_CY]);

      t3_side_q <= t2_side_q;
      t3_view_q <= t2_ok_q && u_in && w_in;
      t3_u_q    <= u_raw[XW-1:0];
      t3_w_q    <= w_raw[YW-1:0];
    end
  end

  // ---------------- mask access ----------------
  logic          pix_in, mask_we, mask_re, mask_bit;
  logic [AW-1:0] mask_addr;

  assign pix_in = (13'(t3_side_q.pix_x) < 13'(MAX_IMAGE_WIDTH)) &&
                  (13'(t3_side_q.pix_y) < 13'(MAX_IMAGE_HEIGHT));

  always_comb begin
    if (!t3_side_q.vox) begin
      mask_addr = AW'(t3_side_q.pix_y) * AW'(MAX_IMAGE_WIDTH) + AW'(t3_side_q.pix_x);
    end else if (t3_view_q) begin
      mask_addr = AW'(t3_w_q) * AW'(MAX_IMAGE_WIDTH) + AW'(t3_u_q);
    end else begin
      mask_addr = '0;
    end
  end

  assign mask_we = en && t3_valid_q && !t3_side_q.vox && pix_in;
  assign mask_re = en && t3_valid_q && t3_side_q.vox;

  vsc_mask #(.DEPTH(DEPTH), .AW(AW)) u_mask (
    .clk_i, .we_i(mask_we), .re_i(mask_re), .addr_i(mask_addr),
    .wdata_i(t3_side_q.mask_bit), .rdata_o(mask_bit)
  );

  logic m_view_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_side_q <= t3_side_q;
      m_view_q <= t3_view_q;
    end
  end

  // ---------------- stage valid bits ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      r1_valid_q <= 1'b0;
      r2_valid_q <= 1'b0;
      r3_valid_q <= 1'b0;
      t0_valid_q <= 1'b0;
      t1_valid_q <= 1'b0;
      t2_valid_q <= 1'b0;
      t3_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else if (en) begin
      p1_valid_q <= b_valid;
      p2_valid_q <= p1_valid_q;
      r1_valid_q <= p2_valid_q;
      r2_valid_q <= r1_valid_q;
      r3_valid_q <= r2_valid_q;
      t0_valid_q <= xd_valid && yd_valid;
      t1_valid_q <= t0_valid_q;
      t2_valid_q <= t1_valid_q;
      t3_valid_q <= t2_valid_q;
      m_valid_q  <= t3_valid_q;
    end
  end

  assign busy = a_busy || b_busy || xd_busy || yd_busy || p1_valid_q || p2_valid_q ||
                r1_valid_q || r2_valid_q || r3_valid_q || t0_valid_q || t1_valid_q ||
                t2_valid_q || t3_valid_q || m_valid_q;

  // ---------------- label update and result buffer ----------------
  res_t res;

  always_comb begin
    res.tag   = m_side_q.tag;
    res.view  = m_view_q;
    res.label = m_side_q.label;
    if (m_view_q && (m_side_q.label != LABEL_CARVED)) begin
      if (!mask_bit) res.label = LABEL_CARVED;
      else if (m_side_q.label == LABEL_UNSEEN) res.label = LABEL_KEPT;
    end
  end

  assign push = en && m_valid_q && m_side_q.vox;

  vsc_ofifo u_ofifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(res), .full_o(fifo_full), .out_if(out_if)
  );

  // ---------------- assertions ----------------
  a_coef_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_if.mode == MODE_COEF)) |-> !busy)
    else $error("coefficient load taken with items in flight");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!fifo_full || (out_if.valid && out_if.ready)) || !fifo_full)
    else $error("result pushed into a full buffer");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> (m_valid_q == $past(m_valid_q)) && (t3_valid_q == $past(t3_valid_q)))
    else $error("pipeline moved during a stall");

  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> (fifo_full && m_valid_q))
    else $error("stall without a full buffer");

endmodule
